// File: sv/asbb_pkg.sv
`default_nettype none
package asbb_pkg;

    // number formats
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int TRIG_FRAC_BITS  = 16;
    localparam int COORD_W         = 32;
    localparam int RAD_W           = 31;
    localparam int ANG_W           = 20;
    localparam int END_W           = ANG_W + 1;
    localparam int BOX_W           = 34;
    localparam int TRIG_W          = TRIG_FRAC_BITS + 2;
    localparam int PROD_W          = RAD_W + TRIG_FRAC_BITS + 1;

    // angle units per turn and the axis angles
    localparam int TURN       = 1 << ANGLE_FRAC_BITS;
    localparam int ANG_YPOS   = 0;
    localparam int ANG_YNEG   = TURN / 2;
    localparam int ANG_ZPOS   = TURN / 4;
    localparam int ANG_ZNEG   = 3 * TURN / 4;

    // internal trig format: coarse table plus residual rotation
    localparam int TF         = 40;
    localparam int TBL_BITS   = 8;
    localparam int RES_BITS   = ANGLE_FRAC_BITS - 2 - TBL_BITS;
    localparam int MUL_SH     = 8;
    localparam int SD_W       = 33;
    localparam int CM_W       = 26;

    // queue between front and back
    localparam int QDEPTH     = 16;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam real PI = 3.14159265358979323846;

    // radians per angle unit
    localparam real RAD_PER_UNIT = 2.0 * PI / (2.0 ** ANGLE_FRAC_BITS);

    typedef logic [(1 << TBL_BITS)-1:0][TF:0] t_base_tbl;
    typedef logic [(1 << RES_BITS)-1:0][TF:0] t_res_tbl;

    typedef struct packed {
        logic                    first;
        logic signed [BOX_W-1:0] y_high;
        logic signed [BOX_W-1:0] y_low;
        logic signed [BOX_W-1:0] z_high;
        logic signed [BOX_W-1:0] z_low;
    } t_box;

    typedef struct packed {
        logic                      first;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic        [RAD_W-1:0]   rad;
        logic        [3:0]         ins;
    } t_side;

    function automatic t_base_tbl make_base(input logic use_sin);
        t_base_tbl t;
        real a;
        for (int i = 0; i < (1 << TBL_BITS); i++) begin
            a = real'(i) * (2.0 ** RES_BITS) * RAD_PER_UNIT;
            if (use_sin)
                t[i] = (TF+1)'(longint'($sin(a) * (2.0 ** TF)));
            else
                t[i] = (TF+1)'(longint'($cos(a) * (2.0 ** TF)));
        end
        return t;
    endfunction

    // residual sine and one minus cosine
    function automatic t_res_tbl make_res(input logic use_sin);
        t_res_tbl t;
        real a;
        real h;
        for (int i = 0; i < (1 << RES_BITS); i++) begin
            a = real'(i) * RAD_PER_UNIT;
            h = $sin(a * 0.5);
            if (use_sin)
                t[i] = (TF+1)'(longint'($sin(a) * (2.0 ** TF)));
            else
                t[i] = (TF+1)'(longint'(2.0 * h * h * (2.0 ** TF)));
        end
        return t;
    endfunction

    localparam t_base_tbl BASE_SIN = make_base(1'b1);
    localparam t_base_tbl BASE_COS = make_base(1'b0);
    localparam t_res_tbl  RES_SIN  = make_res(1'b1);
    localparam t_res_tbl  RES_CM   = make_res(1'b0);

    // axis angle strictly inside (st, en), tested one turn either side
    function automatic logic arc_covers(input logic signed [ANG_W-1:0] st,
                                        input logic signed [END_W-1:0] en,
                                        input int base);
        logic hit;
        logic signed [END_W+1:0] c;
        hit = 1'b0;
        for (int i = -1; i <= 1; i++) begin
            c = (END_W+2)'(i * TURN + base);
            if (c > st && c < en)
                hit = 1'b1;
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

// File: sv/arc_set_bounding_box_top.sv
// throughput: one item per cycle while o_stall is low; trig and scaling are
//   fully pipelined and only the box min/max update in the back end recurs
//   from one item to the next
// reset: synchronous active-low; clears pipeline valids, queue pointers, credit
//   count and the box-holds flag, so the first item after reset starts a new box
`default_nettype none
module arc_set_bounding_box_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // item input
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic                                  i_first_arc,
    input  wire logic signed [asbb_pkg::COORD_W-1:0]   i_center_y,
    input  wire logic signed [asbb_pkg::COORD_W-1:0]   i_center_z,
    input  wire logic        [asbb_pkg::RAD_W-1:0]     i_radius,
    input  wire logic signed [asbb_pkg::ANG_W-1:0]     i_start_angle,
    input  wire logic signed [asbb_pkg::ANG_W-1:0]     i_sweep_angle,
    // box output
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [asbb_pkg::BOX_W-1:0]          o_y_high,
    output logic signed [asbb_pkg::BOX_W-1:0]          o_y_low,
    output logic signed [asbb_pkg::BOX_W-1:0]          o_z_high,
    output logic signed [asbb_pkg::BOX_W-1:0]          o_z_low
);
    // credits count items taken but not yet popped from the queue; the front
    // pipeline never stalls, so a queue slot is reserved for every item on entry
    logic [asbb_pkg::QPTR_W:0] r_cred;
    logic                      take;
    logic                      push, pop, q_empty;
    asbb_pkg::t_box            f_box, q_box;

    assign o_stall = (r_cred == (asbb_pkg::QPTR_W+1)'(asbb_pkg::QDEPTH));
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred <= '0;
        end else begin
            r_cred <= r_cred + (asbb_pkg::QPTR_W+1)'(take) - (asbb_pkg::QPTR_W+1)'(pop);
        end
    end

    // front: trig of both angles, scaling, extremes, per-arc box
    asbb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_first_arc   (i_first_arc),
        .i_center_y    (i_center_y),
        .i_center_z    (i_center_z),
        .i_radius      (i_radius),
        .i_start_angle (i_start_angle),
        .i_sweep_angle (i_sweep_angle),
        .o_push        (push),
        .o_box         (f_box)
    );

    // decoupling queue
    asbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_box),
        .i_pop   (pop),
        .o_data  (q_box),
        .o_empty (q_empty)
    );

    // back: running box merge and output register
    asbb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_box),
        .o_pop     (pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_y_high  (o_y_high),
        .o_y_low   (o_y_low),
        .o_z_high  (o_z_high),
        .o_z_low   (o_z_low)
    );
endmodule
`default_nettype wire

// File: sv/asbb_trig.sv
`default_nettype none
module asbb_trig (
    input  wire logic                                      i_clk,
    input  wire logic        [asbb_pkg::END_W-1:0]         i_angle,
    output logic signed      [asbb_pkg::TRIG_W-1:0]        o_cos,
    output logic signed      [asbb_pkg::TRIG_W-1:0]        o_sin
);
    localparam int TF   = asbb_pkg::TF;
    localparam int QB   = asbb_pkg::ANGLE_FRAC_BITS - 2;
    localparam int TFB  = asbb_pkg::TRIG_FRAC_BITS;
    localparam int RSH  = TF - TFB;
    localparam int S8_W = TF - asbb_pkg::MUL_SH + 1;
    localparam int PSD  = S8_W + asbb_pkg::SD_W;
    localparam int PCM  = S8_W + asbb_pkg::CM_W;

    logic [asbb_pkg::ANGLE_FRAC_BITS-1:0] ang;
    logic [asbb_pkg::TBL_BITS-1:0]        idx;
    logic [asbb_pkg::RES_BITS-1:0]        res;

    // table stage
    logic [1:0]                   r_qb;
    logic [TF:0]                  r_bs, r_bc;
    logic [asbb_pkg::SD_W-1:0]    r_sd;
    logic [asbb_pkg::CM_W-1:0]    r_cm;

    // product stage
    logic [1:0]  r_qc;
    logic [TF:0] r_cs, r_cc, r_t_scm, r_t_csd, r_t_ccm, r_t_ssd;

    logic [S8_W-1:0] s8, c8;
    logic [PSD-1:0]  m_csd, m_ssd;
    logic [PCM-1:0]  m_scm, m_ccm;

    logic signed [TF+2:0] vs, vc;
    logic [TF+1:0]        us, uc;
    logic [TFB:0]         rs, rc;
    logic signed [asbb_pkg::TRIG_W-1:0] sr, cr;

    assign ang = i_angle[asbb_pkg::ANGLE_FRAC_BITS-1:0];
    assign idx = ang[QB-1 -: asbb_pkg::TBL_BITS];
    assign res = ang[asbb_pkg::RES_BITS-1:0];

    always_ff @(posedge i_clk) begin
        r_qb <= ang[asbb_pkg::ANGLE_FRAC_BITS-1 -: 2];
        r_bs <= asbb_pkg::BASE_SIN[idx];
        r_bc <= asbb_pkg::BASE_COS[idx];
        r_sd <= asbb_pkg::RES_SIN[res][asbb_pkg::SD_W-1:0];
        r_cm <= asbb_pkg::RES_CM[res][asbb_pkg::CM_W-1:0];
    end

    assign s8    = r_bs[TF:asbb_pkg::MUL_SH];
    assign c8    = r_bc[TF:asbb_pkg::MUL_SH];
    assign m_csd = PSD'(c8) * PSD'(r_sd);
    assign m_ssd = PSD'(s8) * PSD'(r_sd);
    assign m_scm = PCM'(s8) * PCM'(r_cm);
    assign m_ccm = PCM'(c8) * PCM'(r_cm);

    always_ff @(posedge i_clk) begin
        r_qc    <= r_qb;
        r_cs    <= r_bs;
        r_cc    <= r_bc;
        r_t_csd <= (TF+1)'(m_csd >> (S8_W - 1));
        r_t_ssd <= (TF+1)'(m_ssd >> (S8_W - 1));
        r_t_scm <= (TF+1)'(m_scm >> (S8_W - 1));
        r_t_ccm <= (TF+1)'(m_ccm >> (S8_W - 1));
    end

    // sin(a+d) = sin a - sin a (1 - cos d) + cos a sin d, likewise for cos
    always_comb begin
        vs = signed'({2'b00, r_cs}) - signed'({2'b00, r_t_scm}) + signed'({2'b00, r_t_csd});
        vc = signed'({2'b00, r_cc}) - signed'({2'b00, r_t_ccm}) - signed'({2'b00, r_t_ssd});
        if (vs < 0)
            vs = '0;
        if (vc < 0)
            vc = '0;
        us = {1'b0, vs[TF:0]} + ((TF+2)'(1) << (RSH - 1));
        uc = {1'b0, vc[TF:0]} + ((TF+2)'(1) << (RSH - 1));
        rs = (TFB+1)'(us >> RSH);
        rc = (TFB+1)'(uc >> RSH);
        sr = signed'({1'b0, rs});
        cr = signed'({1'b0, rc});
    end

    always_ff @(posedge i_clk) begin
        unique case (r_qc)
            2'd0: begin
                o_cos <= cr;
                o_sin <= sr;
            end
            2'd1: begin
                o_cos <= -sr;
                o_sin <= cr;
            end
            2'd2: begin
                o_cos <= -cr;
                o_sin <= -sr;
            end
            default: begin
                o_cos <= sr;
                o_sin <= -cr;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: sv/asbb_front.sv
`default_nettype none
module asbb_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_take,
    input  wire logic                                  i_first_arc,
    input  wire logic signed [asbb_pkg::COORD_W-1:0]   i_center_y,
    input  wire logic signed [asbb_pkg::COORD_W-1:0]   i_center_z,
    input  wire logic        [asbb_pkg::RAD_W-1:0]     i_radius,
    input  wire logic signed [asbb_pkg::ANG_W-1:0]     i_start_angle,
    input  wire logic signed [asbb_pkg::ANG_W-1:0]     i_sweep_angle,
    output logic                                       o_push,
    output asbb_pkg::t_box                             o_box
);
    localparam int BW  = asbb_pkg::BOX_W;
    localparam int TFB = asbb_pkg::TRIG_FRAC_BITS;
    localparam int NST = 7;

    logic [NST-1:0] r_vld;

    // entry stage
    logic                                 r_a_first;
    logic signed [asbb_pkg::COORD_W-1:0]  r_a_cy, r_a_cz;
    logic        [asbb_pkg::RAD_W-1:0]    r_a_rad;
    logic signed [asbb_pkg::ANG_W-1:0]    r_a_st;
    logic signed [asbb_pkg::END_W-1:0]    r_a_en;

    asbb_pkg::t_side r_side [3];
    asbb_pkg::t_side a_side;

    logic signed [asbb_pkg::TRIG_W-1:0] c0, s0, c1, s1;
    logic signed [asbb_pkg::TRIG_W-1:0] tv [4];

    // scale stage
    logic [asbb_pkg::PROD_W-1:0] r_e_p [4];
    logic [3:0]                  r_e_neg;
    asbb_pkg::t_side             r_e_side;

    // point stage
    logic signed [BW-1:0] r_f_pt [4];
    logic signed [BW-1:0] r_f_ext [4];
    logic [3:0]           r_f_ins;
    logic                 r_f_first;

    logic [TFB:0]                  mag [4];
    logic [asbb_pkg::PROD_W:0]     rnd [4];
    logic signed [BW-1:0]          off [4];
    logic signed [BW-1:0]          pt  [4];
    logic signed [BW-1:0]          ext [4];
    logic signed [BW-1:0]          yh, yl, zh, zl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NST-2:0], i_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_a_first <= i_first_arc;
            r_a_cy    <= i_center_y;
            r_a_cz    <= i_center_z;
            r_a_rad   <= i_radius;
            r_a_st    <= i_start_angle;
            r_a_en    <= {i_start_angle[asbb_pkg::ANG_W-1], i_start_angle}
                       + {i_sweep_angle[asbb_pkg::ANG_W-1], i_sweep_angle};
        end
    end

    always_comb begin
        a_side.first  = r_a_first;
        a_side.cy     = r_a_cy;
        a_side.cz     = r_a_cz;
        a_side.rad    = r_a_rad;
        a_side.ins[0] = asbb_pkg::arc_covers(r_a_st, r_a_en, asbb_pkg::ANG_YPOS);
        a_side.ins[1] = asbb_pkg::arc_covers(r_a_st, r_a_en, asbb_pkg::ANG_YNEG);
        a_side.ins[2] = asbb_pkg::arc_covers(r_a_st, r_a_en, asbb_pkg::ANG_ZPOS);
        a_side.ins[3] = asbb_pkg::arc_covers(r_a_st, r_a_en, asbb_pkg::ANG_ZNEG);
    end

    // side data travels beside the three trig stages
    always_ff @(posedge i_clk) begin
        r_side[0] <= a_side;
        r_side[1] <= r_side[0];
        r_side[2] <= r_side[1];
    end

    asbb_trig u_trig_st (
        .i_clk   (i_clk),
        .i_angle ({r_a_st[asbb_pkg::ANG_W-1], r_a_st}),
        .o_cos   (c0),
        .o_sin   (s0)
    );

    asbb_trig u_trig_en (
        .i_clk   (i_clk),
        .i_angle (r_a_en),
        .o_cos   (c1),
        .o_sin   (s1)
    );

    assign tv[0] = c0;
    assign tv[1] = c1;
    assign tv[2] = s0;
    assign tv[3] = s1;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mag[k] = tv[k][asbb_pkg::TRIG_W-1] ? (TFB+1)'(-tv[k]) : (TFB+1)'(tv[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_e_p[k]   <= asbb_pkg::PROD_W'(r_side[2].rad) * asbb_pkg::PROD_W'(mag[k]);
            r_e_neg[k] <= tv[k][asbb_pkg::TRIG_W-1];
        end
        r_e_side <= r_side[2];
    end

    // round to nearest, ties away from zero, then add the centre
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rnd[k] = ({1'b0, r_e_p[k]} + ((asbb_pkg::PROD_W+1)'(1) << (TFB - 1))) >> TFB;
            off[k] = r_e_neg[k] ? -signed'(BW'(rnd[k])) : signed'(BW'(rnd[k]));
        end
        pt[0]  = BW'(r_e_side.cy) + off[0];
        pt[1]  = BW'(r_e_side.cy) + off[1];
        pt[2]  = BW'(r_e_side.cz) + off[2];
        pt[3]  = BW'(r_e_side.cz) + off[3];
        ext[0] = BW'(r_e_side.cy) + signed'(BW'(r_e_side.rad));
        ext[1] = BW'(r_e_side.cy) - signed'(BW'(r_e_side.rad));
        ext[2] = BW'(r_e_side.cz) + signed'(BW'(r_e_side.rad));
        ext[3] = BW'(r_e_side.cz) - signed'(BW'(r_e_side.rad));
    end

    always_ff @(posedge i_clk) begin
        r_f_pt    <= pt;
        r_f_ext   <= ext;
        r_f_ins   <= r_e_side.ins;
        r_f_first <= r_e_side.first;
    end

    always_comb begin
        yh = (r_f_pt[0] >= r_f_pt[1]) ? r_f_pt[0] : r_f_pt[1];
        yl = (r_f_pt[0] <= r_f_pt[1]) ? r_f_pt[0] : r_f_pt[1];
        zh = (r_f_pt[2] >= r_f_pt[3]) ? r_f_pt[2] : r_f_pt[3];
        zl = (r_f_pt[2] <= r_f_pt[3]) ? r_f_pt[2] : r_f_pt[3];
        if (r_f_ins[0] && r_f_ext[0] > yh)
            yh = r_f_ext[0];
        if (r_f_ins[1] && r_f_ext[1] < yl)
            yl = r_f_ext[1];
        if (r_f_ins[2] && r_f_ext[2] > zh)
            zh = r_f_ext[2];
        if (r_f_ins[3] && r_f_ext[3] < zl)
            zl = r_f_ext[3];
    end

    always_ff @(posedge i_clk) begin
        o_box.first  <= r_f_first;
        o_box.y_high <= yh;
        o_box.y_low  <= yl;
        o_box.z_high <= zh;
        o_box.z_low  <= zl;
    end

    assign o_push = r_vld[NST-1];
endmodule
`default_nettype wire

// File: sv/asbb_queue.sv
`default_nettype none
module asbb_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire asbb_pkg::t_box i_data,
    input  wire logic           i_pop,
    output asbb_pkg::t_box      o_data,
    output logic                o_empty
);
    asbb_pkg::t_box                r_mem [asbb_pkg::QDEPTH];
    logic [asbb_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [asbb_pkg::QPTR_W:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= r_wr + 1'b1;
            if (i_pop)
                r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (asbb_pkg::QPTR_W+1)'(i_push) - (asbb_pkg::QPTR_W+1)'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
endmodule
`default_nettype wire

// File: sv/asbb_back.sv
`default_nettype none
module asbb_back (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_q_empty,
    input  wire asbb_pkg::t_box                      i_q_data,
    output logic                                     o_pop,
    input  wire logic                                i_stall,
    output logic                                     o_valid,
    output logic signed [asbb_pkg::BOX_W-1:0]        o_y_high,
    output logic signed [asbb_pkg::BOX_W-1:0]        o_y_low,
    output logic signed [asbb_pkg::BOX_W-1:0]        o_z_high,
    output logic signed [asbb_pkg::BOX_W-1:0]        o_z_low
);
    logic r_valid, r_holds;
    logic signed [asbb_pkg::BOX_W-1:0] r_yh, r_yl, r_zh, r_zl;
    logic restart;

    assign o_pop   = !i_q_empty && (!r_valid || !i_stall);
    assign restart = i_q_data.first || !r_holds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_holds <= 1'b0;
        end else begin
            if (o_pop)
                r_holds <= 1'b1;
            if (o_pop)
                r_valid <= 1'b1;
            else if (!i_stall)
                r_valid <= 1'b0;
        end
    end

    // the box registers double as the output register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (restart || i_q_data.y_high > r_yh)
                r_yh <= i_q_data.y_high;
            if (restart || i_q_data.y_low < r_yl)
                r_yl <= i_q_data.y_low;
            if (restart || i_q_data.z_high > r_zh)
                r_zh <= i_q_data.z_high;
            if (restart || i_q_data.z_low < r_zl)
                r_zl <= i_q_data.z_low;
        end
    end

    assign o_valid  = r_valid;
    assign o_y_high = r_yh;
    assign o_y_low  = r_yl;
    assign o_z_high = r_zh;
    assign o_z_low  = r_zl;
endmodule
`default_nettype wire

// File: sv/asbb_chk.sv
`default_nettype none
module asbb_chk (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  o_stall,
    input wire logic                                  o_valid,
    input wire logic                                  i_stall,
    input wire logic signed [asbb_pkg::BOX_W-1:0]     o_y_high,
    input wire logic signed [asbb_pkg::BOX_W-1:0]     o_y_low,
    input wire logic signed [asbb_pkg::BOX_W-1:0]     o_z_high,
    input wire logic signed [asbb_pkg::BOX_W-1:0]     o_z_low
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_y_high) && $stable(o_y_low)
                               && $stable(o_z_high) && $stable(o_z_low))
        else $error("stalled box changed");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_y_low <= o_y_high && o_z_low <= o_z_high)
        else $error("box bounds crossed");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid && !o_stall)
        else $error("not idle after reset");

    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown({o_y_high, o_y_low, o_z_high, o_z_low}))
        else $error("unknown bits on a valid box");
endmodule

bind arc_set_bounding_box_top asbb_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_y_high    (o_y_high),
    .o_y_low     (o_y_low),
    .o_z_high    (o_z_high),
    .o_z_low     (o_z_low)
);
`default_nettype wire

// File: tb/arc_set_bounding_box_top_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module arc_set_bounding_box_top_tb;
    import asbb_pkg::*;

    localparam int        WATCHDOG_LIMIT = 5000;
    localparam int        LONG_HOLD      = 300;
    localparam int        DRAIN_CYCLES   = 30;
    localparam bit [63:0] PI_Q61         = 64'h6487ED5110B4611A;
    localparam bit [63:0] ONE_Q62        = 64'h4000000000000000;
    localparam int        SERIES_TERMS   = 13;

    typedef struct {
        logic signed [BOX_W-1:0] y_high;
        logic signed [BOX_W-1:0] y_low;
        logic signed [BOX_W-1:0] z_high;
        logic signed [BOX_W-1:0] z_low;
    } t_exp_box;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_first_arc;
    logic signed [COORD_W-1:0] i_center_y;
    logic signed [COORD_W-1:0] i_center_z;
    logic        [RAD_W-1:0]   i_radius;
    logic signed [ANG_W-1:0]   i_start_angle;
    logic signed [ANG_W-1:0]   i_sweep_angle;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [BOX_W-1:0]   o_y_high;
    logic signed [BOX_W-1:0]   o_y_low;
    logic signed [BOX_W-1:0]   o_z_high;
    logic signed [BOX_W-1:0]   o_z_low;

    // predictor copy of the running box
    longint run_y_high, run_y_low, run_z_high, run_z_low;
    bit     run_has_arc;

    t_exp_box pending_boxes[$];
    int     mismatches;
    int     arcs_sent;
    int     boxes_checked;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     hold_go;
    int     hold_left;
    int     quiet_cycles;

    arc_set_bounding_box_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_first_arc   (i_first_arc),
        .i_center_y    (i_center_y),
        .i_center_z    (i_center_z),
        .i_radius      (i_radius),
        .i_start_angle (i_start_angle),
        .i_sweep_angle (i_sweep_angle),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_y_high      (o_y_high),
        .o_y_low       (o_y_low),
        .o_z_high      (o_z_high),
        .o_z_low       (o_z_low)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor: fixed-point trig and box update
    // ---------------------------------------------------------------

    // (a * b) >> s on the full 128-bit product
    function automatic bit [63:0] mul_shift(input bit [63:0] a, input bit [63:0] b,
                                            input int s);
        bit [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p >> s);
    endfunction

    function automatic longint round_q62(input longint v);
        bit [63:0] u;
        if (v < 0)
            v = 0;
        u = 64'(v) + (64'd1 << (61 - TRIG_FRAC_BITS));
        return longint'(u >> (62 - TRIG_FRAC_BITS));
    endfunction

    // cosine and sine at an angle in turn units, rounded to the trig format
    task automatic cos_sin(input longint ang, output longint c, output longint s);
        bit [63:0] r, f, x, x2, ts, tc;
        int        q;
        longint    ss, sc, cr, sr;
        r  = 64'(ang) & ((64'd1 << ANGLE_FRAC_BITS) - 1);
        q  = int'(r >> (ANGLE_FRAC_BITS - 2));
        f  = r & ((64'd1 << (ANGLE_FRAC_BITS - 2)) - 1);
        x  = mul_shift(f, PI_Q61, ANGLE_FRAC_BITS - 2);
        x2 = mul_shift(x, x, 62);
        ts = x;
        tc = ONE_Q62;
        ss = longint'(x);
        sc = longint'(ONE_Q62);
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            ts = mul_shift(ts, x2, 62) / 64'((2 * k) * (2 * k + 1));
            tc = mul_shift(tc, x2, 62) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                ss -= longint'(ts);
                sc -= longint'(tc);
            end else begin
                ss += longint'(ts);
                sc += longint'(tc);
            end
        end
        cr = round_q62(sc);
        sr = round_q62(ss);
        case (q)
            0: begin c = cr;  s = sr;  end
            1: begin c = -sr; s = cr;  end
            2: begin c = -cr; s = -sr; end
            default: begin c = sr; s = -cr; end
        endcase
    endtask

    // radius times trig value, nearest with ties away from zero
    function automatic longint scale_radius(input longint rad, input longint t);
        bit [63:0] p;
        longint    m;
        p = 64'(rad) * 64'(t < 0 ? -t : t);
        m = longint'((p + (64'd1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS);
        return t < 0 ? -m : m;
    endfunction

    // axis angle strictly between start and end, one turn either side
    function automatic bit axis_crossed(input longint st, input longint en, input longint base);
        longint c;
        for (int i = -1; i <= 1; i++) begin
            c = i * TURN + base;
            if (c > st && c < en)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic grow_box(input bit first, input longint cy, input longint cz,
                            input longint rad, input longint st, input longint sw,
                            output t_exp_box b);
        longint en, c0, s0, c1, s1, y1, y2, z1, z2, yh, yl, zh, zl;
        en = st + sw;
        cos_sin(st, c0, s0);
        cos_sin(en, c1, s1);
        y1 = cy + scale_radius(rad, c0);
        y2 = cy + scale_radius(rad, c1);
        z1 = cz + scale_radius(rad, s0);
        z2 = cz + scale_radius(rad, s1);
        yh = y1 >= y2 ? y1 : y2;
        yl = y1 <= y2 ? y1 : y2;
        zh = z1 >= z2 ? z1 : z2;
        zl = z1 <= z2 ? z1 : z2;
        if (axis_crossed(st, en, ANG_YPOS) && cy + rad > yh) yh = cy + rad;
        if (axis_crossed(st, en, ANG_YNEG) && cy - rad < yl) yl = cy - rad;
        if (axis_crossed(st, en, ANG_ZPOS) && cz + rad > zh) zh = cz + rad;
        if (axis_crossed(st, en, ANG_ZNEG) && cz - rad < zl) zl = cz - rad;
        // an extend on an empty box starts it as well
        if (first || !run_has_arc) begin
            run_y_high  = yh;
            run_y_low   = yl;
            run_z_high  = zh;
            run_z_low   = zl;
            run_has_arc = 1'b1;
        end else begin
            if (yh > run_y_high) run_y_high = yh;
            if (yl < run_y_low)  run_y_low  = yl;
            if (zh > run_z_high) run_z_high = zh;
            if (zl < run_z_low)  run_z_low  = zl;
        end
        b.y_high = BOX_W'(run_y_high);
        b.y_low  = BOX_W'(run_y_low);
        b.z_high = BOX_W'(run_z_high);
        b.z_low  = BOX_W'(run_z_low);
    endtask

    // ---------------------------------------------------------------
    // sender: offers one arc and waits for it to be taken
    // ---------------------------------------------------------------
    task automatic send_arc(input bit first, input logic signed [COORD_W-1:0] cy,
                            input logic signed [COORD_W-1:0] cz,
                            input logic [RAD_W-1:0] rad,
                            input logic signed [ANG_W-1:0] st,
                            input logic signed [ANG_W-1:0] sw);
        t_exp_box b;
        // random gap before the item, valid dropped only when a gap is taken
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid       <= 1'b1;
        i_first_arc   <= first;
        i_center_y    <= cy;
        i_center_z    <= cz;
        i_radius      <= rad;
        i_start_angle <= st;
        i_sweep_angle <= sw;
        do @(posedge i_clk); while (o_stall);
        grow_box(first, longint'(cy), longint'(cz), longint'(rad), longint'(st),
                 longint'(sw), b);
        pending_boxes.push_back(b);
        arcs_sent++;
    endtask

    // random angle, biased toward the quadrant boundaries and their neighbours
    function automatic logic signed [ANG_W-1:0] pick_angle();
        int q;
        case ($urandom_range(3))
            0: return ANG_W'($urandom);
            1: begin
                q = $urandom_range(7) * (TURN / 4) - TURN;
                return ANG_W'(q + $urandom_range(2) - 1);
            end
            default: return ANG_W'(int'($urandom_range(2 * TURN)) - TURN);
        endcase
    endfunction

    function automatic logic signed [ANG_W-1:0] pick_sweep();
        case ($urandom_range(5))
            0: return ANG_W'($urandom);
            1: return ANG_W'(-int'($urandom_range(TURN)));
            2: return '0;
            3: return ANG_W'(TURN + $urandom_range(TURN));
            default: return ANG_W'($urandom_range(TURN));
        endcase
    endfunction

    function automatic logic [RAD_W-1:0] pick_radius();
        case ($urandom_range(3))
            0: return RAD_W'($urandom);
            1: return RAD_W'($urandom_range(255));
            default: return RAD_W'($urandom_range(32'h00FF_FFFF));
        endcase
    endfunction

    task automatic send_random_arc();
        send_arc($urandom_range(7) == 0, COORD_W'($urandom), COORD_W'($urandom),
                 pick_radius(), pick_angle(), pick_sweep());
    endtask

    task automatic wait_boxes_drained();
        while (pending_boxes.size() > 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [RAD_W-1:0]          R_MAX = '1;
    localparam logic signed [ANG_W-1:0]   A_MAX = {1'b0, {(ANG_W-1){1'b1}}};
    localparam logic signed [ANG_W-1:0]   A_MIN = {1'b1, {(ANG_W-1){1'b0}}};

    task automatic test_directed();
        // extend on an empty box right after reset
        send_arc(1'b0, 32'sh0001_0000, -32'sh0002_0000, 31'h0001_0000, 20'sd0, 20'sd16384);
        // each axis extreme exactly at an end, then strictly inside
        send_arc(1'b1, '0, '0, 31'h0001_0000, 20'sd0,     20'sd65536);
        send_arc(1'b1, '0, '0, 31'h0001_0000, 20'sd1,     20'sd65534);
        send_arc(1'b1, '0, '0, 31'h0003_0000, 20'sd16384, 20'sd32768);
        send_arc(1'b0, '0, '0, 31'h0003_0000, 20'sd49151, 20'sd2);
        // zero and negative sweeps: endpoints only
        send_arc(1'b1, 32'sh0100_0000, 32'sh0100_0000, 31'h0010_0000, 20'sd100, 20'sd0);
        send_arc(1'b0, 32'sh0100_0000, 32'sh0100_0000, 31'h0010_0000, 20'sd100, -20'sd60000);
        // angles and sweeps beyond one turn
        send_arc(1'b1, '0, '0, 31'h0000_8000, -20'sd70000, 20'sd200000);
        send_arc(1'b0, '0, '0, 31'h0000_8000, 20'sd300000, 20'sd5);
        // field extremes
        send_arc(1'b1, C_MAX, C_MAX, R_MAX, A_MIN, A_MAX);
        send_arc(1'b0, C_MIN, C_MIN, R_MAX, A_MAX, A_MIN);
        send_arc(1'b1, C_MIN, C_MAX, R_MAX, A_MAX, A_MAX);
        send_arc(1'b0, C_MAX, C_MIN, R_MAX, A_MIN, A_MIN);
        send_arc(1'b1, '0, '0, '0, '0, '0);
        send_arc(1'b1, -32'sd1, -32'sd1, 31'd1, -20'sd1, -20'sd1);
        send_arc(1'b0, C_MAX, C_MIN, R_MAX, 20'sd32768, 20'sd1);
        i_valid <= 1'b0;
        wait_boxes_drained();
    endtask

    task automatic test_random(input int n_arcs, input int snd_pct, input int rcv_pct);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        repeat (n_arcs)
            send_random_arc();
    endtask

    // long receiver hold while the sender keeps offering, so the block backs up
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b1;
        repeat (60)
            send_random_arc();
    endtask

    // sender stops until every box has come back, then resumes
    task automatic test_sender_pause();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        repeat (20)
            send_random_arc();
        i_valid <= 1'b0;
        wait_boxes_drained();
        repeat (20)
            send_random_arc();
    endtask

    // ---------------------------------------------------------------
    // receiver: random stall, long hold on request, result check
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [BOX_W-1:0] got,
                                   input logic [BOX_W-1:0] want);
        mismatches++;
        $display("box %0d: %s got %0h expected %0h", boxes_checked, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_exp_box want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_boxes.size() == 0) begin
                report_mismatch("unexpected box, y_high", o_y_high, '0);
            end else begin
                want = pending_boxes.pop_front();
                if (o_y_high !== want.y_high) report_mismatch("y_high", o_y_high, want.y_high);
                if (o_y_low  !== want.y_low)  report_mismatch("y_low",  o_y_low,  want.y_low);
                if (o_z_high !== want.z_high) report_mismatch("z_high", o_z_high, want.z_high);
                if (o_z_low  !== want.z_low)  report_mismatch("z_low",  o_z_low,  want.z_low);
            end
            boxes_checked++;
        end
        if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        mismatches    = 0;
        arcs_sent     = 0;
        boxes_checked = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go       = 1'b0;
        hold_left     = 0;
        quiet_cycles  = 0;
        run_y_high    = 0;
        run_y_low     = 0;
        run_z_high    = 0;
        run_z_low     = 0;
        run_has_arc   = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_first_arc   = 1'b0;
        i_center_y    = '0;
        i_center_z    = '0;
        i_radius      = '0;
        i_start_angle = '0;
        i_sweep_angle = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(600, 10, 56);
        test_random(600, 56, 10);
        test_random(560, 0, 0);
        test_backpressure();
        test_sender_pause();

        i_valid <= 1'b0;
        wait_boxes_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d arcs sent with directed extremes, random spans and stalls", arcs_sent);
        $display("%0d boxes checked, %0d mismatches", boxes_checked, mismatches);
        if (mismatches == 0 && pending_boxes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
